// File: rtl/core/rmmn_pkg.sv
// Shared constants and types for the RGBA min-max contrast stretch block.
// Used by the frame RAM, the divider lane and the top level; depends on nothing.
package rmmn_pkg;

	localparam int FramePixels = 4096;
	localparam int AddrW = (FramePixels > 1) ? $clog2(FramePixels) : 1;
	localparam int CountW = $clog2(FramePixels + 1);
	localparam int PixelW = 32;
	localparam int ChanW = 8;
	localparam int NumChans = 3;
	localparam int StepCntW = $clog2(ChanW);

	localparam logic CmdLoad = 1'b0;
	localparam logic CmdEmit = 1'b1;
	localparam logic ModeGray = 1'b0;
	localparam logic ModeRgba = 1'b1;

	localparam logic [ChanW-1:0] ChanMax = '1;
	localparam logic [ChanW-1:0] AlphaByte = '1;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

endpackage

// File: rtl/core/rmmn_frame_ram.sv
// Frame memory: one write port and one read port with registered read data.
// Depends on rmmn_pkg for depth and word width.
module rmmn_frame_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [rmmn_pkg::AddrW-1:0]  waddr,
	input  logic [rmmn_pkg::PixelW-1:0] wdata,
	input  logic                        re,
	input  logic [rmmn_pkg::AddrW-1:0]  raddr,
	output logic [rmmn_pkg::PixelW-1:0] rdata
);

	logic [rmmn_pkg::PixelW-1:0] mem [rmmn_pkg::FramePixels];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/rmmn_div_lane.sv
// One channel of the stretch: (v - lo) * 255 / (hi - lo), one quotient bit per step.
// Depends on rmmn_pkg for the channel width and the control struct.
module rmmn_div_lane (
	input  logic                       clk,
	input  rmmn_pkg::div_ctrl_t        ctrl,
	input  logic [rmmn_pkg::ChanW-1:0] v,
	input  logic [rmmn_pkg::ChanW-1:0] lo,
	input  logic [rmmn_pkg::ChanW-1:0] hi,
	output logic [rmmn_pkg::ChanW-1:0] res
);

	localparam int W = rmmn_pkg::ChanW;

	logic [W-1:0]   diff;
	logic [2*W-1:0] num;
	logic [W-1:0]   den;
	logic           zero;
	logic           sat;
	logic [W:0]     rem_shift;
	logic [W:0]     rem_sub;
	logic           ge;

	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] den_q;
	logic         zero_q;
	logic         sat_q;

	always_comb begin
		diff = v - lo;
		num = {diff, {W{1'b0}}} - {{W{1'b0}}, diff};
		den = hi - lo;
		zero = (hi <= lo) || (v <= lo);
		sat = (v >= hi);
		rem_shift = {rem_q, quo_q[W-1]};
		ge = (rem_shift >= {1'b0, den_q});
		rem_sub = rem_shift - {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q <= num[2*W-1:W];
			quo_q <= num[W-1:0];
			den_q <= den;
			zero_q <= zero;
			sat_q <= sat;
		end else if (ctrl.step) begin
			rem_q <= ge ? rem_sub[W-1:0] : rem_shift[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign res = zero_q ? '0 : (sat_q ? rmmn_pkg::ChanMax : quo_q);

endmodule

// File: rtl/core/rgba_min_max_normalize_top.sv
// Top level of the min-max contrast stretch: frame RAM, statistics, sequencer, output register.
// Depends on rmmn_pkg, rmmn_frame_ram and rmmn_div_lane.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_stall    command, first, pixel_in
//   output    out_valid / out_stall  pixel_out, last
//   config    cfg_we                 cfg_wdata (color_mode)
//
// An emit word passes through acceptance with the RAM read, a setup state (ST_FETCH) for
// three divider lanes, 8 quotient-bit steps (ST_DIV) and a state that fills the output
// register (ST_FINISH); it waits longer while a previous result is held.
// Reset clears counts, statistics and control; the frame RAM is not cleared.
// Loads are taken while a finished result still waits in the output register.
module rgba_min_max_normalize_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        command,
	input  logic                        first,
	input  logic [rmmn_pkg::PixelW-1:0] pixel_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rmmn_pkg::PixelW-1:0] pixel_out,
	output logic                        last,
	input  logic                        cfg_we,
	input  logic                        cfg_wdata
);

	localparam int W = rmmn_pkg::ChanW;
	localparam int NC = rmmn_pkg::NumChans;
	localparam int AW = rmmn_pkg::AddrW;
	localparam int CW = rmmn_pkg::CountW;
	localparam int SW = rmmn_pkg::StepCntW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t st_q;
	logic [SW-1:0] step_q;
	logic out_valid_q;
	logic [rmmn_pkg::PixelW-1:0] pixel_out_q;
	logic last_q;
	logic last_s1;
	logic mode_s1;

	logic mode_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] ri_q;
	logic [W-1:0] min_q [NC];
	logic [W-1:0] max_q [NC];

	logic in_acc;
	logic load_acc;
	logic emit_acc;
	logic [CW-1:0] cnt_base;
	logic full;
	logic [AW-1:0] idx;
	logic is_last;
	logic [W-1:0] ld_v [NC];
	logic [W-1:0] base_min [NC];
	logic [W-1:0] base_max [NC];
	logic ld_en [NC];
	logic [rmmn_pkg::PixelW-1:0] rdata;
	logic [W-1:0] lane_v [NC];
	logic [W-1:0] lane_res [NC];
	rmmn_pkg::div_ctrl_t div_ctrl;
	logic out_free;

	assign in_stall = (st_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign load_acc = in_acc && (command == rmmn_pkg::CmdLoad);
	assign emit_acc = in_acc && (command == rmmn_pkg::CmdEmit) && (cnt_q != '0);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cnt_base = first ? '0 : cnt_q;
		full = (cnt_base >= CW'(rmmn_pkg::FramePixels));
		idx = (CW'(ri_q) >= cnt_q) ? '0 : ri_q;
		is_last = ((CW'(idx) + CW'(1)) == cnt_q);
		for (int c = 0; c < NC; c++) begin
			ld_v[c] = (mode_q == rmmn_pkg::ModeGray) ? pixel_in[W-1:0]
				: pixel_in[rmmn_pkg::PixelW-1-W*c -: W];
			lane_v[c] = (mode_s1 == rmmn_pkg::ModeGray) ? rdata[W-1:0]
				: rdata[rmmn_pkg::PixelW-1-W*c -: W];
			ld_en[c] = !full && ((c == 0) || (mode_q == rmmn_pkg::ModeRgba));
			base_min[c] = first ? rmmn_pkg::ChanMax : min_q[c];
			base_max[c] = first ? '0 : max_q[c];
		end
		div_ctrl.load = (st_q == ST_FETCH);
		div_ctrl.step = (st_q == ST_DIV);
	end

	rmmn_frame_ram u_ram (
		.clk   (clk),
		.we    (load_acc && !full),
		.waddr (cnt_base[AW-1:0]),
		.wdata (pixel_in),
		.re    (emit_acc),
		.raddr (idx),
		.rdata (rdata)
	);

	for (genvar c = 0; c < NC; c++) begin : g_lane
		rmmn_div_lane u_lane (
			.clk  (clk),
			.ctrl (div_ctrl),
			.v    (lane_v[c]),
			.lo   (min_q[c]),
			.hi   (max_q[c]),
			.res  (lane_res[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rmmn_pkg::ModeRgba;
			cnt_q <= '0;
			ri_q <= '0;
			for (int c = 0; c < NC; c++) begin
				min_q[c] <= rmmn_pkg::ChanMax;
				max_q[c] <= '0;
			end
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (load_acc) begin
				cnt_q <= full ? cnt_base : cnt_base + CW'(1);
				if (first) begin
					ri_q <= '0;
				end
				for (int c = 0; c < NC; c++) begin
					min_q[c] <= (ld_en[c] && (ld_v[c] < base_min[c])) ? ld_v[c] : base_min[c];
					max_q[c] <= (ld_en[c] && (ld_v[c] > base_max[c])) ? ld_v[c] : base_max[c];
				end
			end
			if (emit_acc) begin
				ri_q <= is_last ? '0 : idx + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
			pixel_out_q <= '0;
			last_q <= 1'b0;
			last_s1 <= 1'b0;
			mode_s1 <= rmmn_pkg::ModeRgba;
		end else begin
			if ((st_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (emit_acc) begin
						last_s1 <= is_last;
						mode_s1 <= mode_q;
						st_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					step_q <= '0;
					st_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(W - 1)) begin
						st_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						last_q <= last_s1;
						if (mode_s1 == rmmn_pkg::ModeRgba) begin
							pixel_out_q <= {lane_res[0], lane_res[1], lane_res[2],
								rmmn_pkg::AlphaByte};
						end else begin
							pixel_out_q <= {{(rmmn_pkg::PixelW-W){1'b0}}, lane_res[0]};
						end
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign last = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(rmmn_pkg::FramePixels))
		else $error("pixel count exceeds frame capacity");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ri_q == '0) || (CW'(ri_q) < cnt_q))
		else $error("read index beyond stored pixels");

	a_emit_starts: assert property (@(posedge clk) disable iff (!arst_n)
		emit_acc |=> (st_q == ST_FETCH))
		else $error("accepted emit did not start a fetch");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == ST_FINISH))
		else $error("result appeared without a finished computation");

endmodule
